// ----- design/nllt_pkg.sv -----
// Shared types and constants for the NACK loss list tracker.
// Used by nllt_ctrl, nllt_dp and nack_loss_list_tracker; depends on nothing.
`default_nettype none

package nllt_pkg;

    localparam int SEQ_FIELD_W = 32;
    localparam int STATION_W   = 8;
    localparam int COUNT_W     = 16;
    localparam int SEND_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int IN_DATA_W   = 56;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 88;
    localparam int OUT_USER_W  = 5;

    localparam logic [COUNT_W-1:0] WINDOW_LIMIT_RST = 16'd64;
    localparam logic [SEND_W-1:0]  MAX_SEND_RST     = 4'd3;
    localparam logic [SEND_W-1:0]  SEND_SAT         = 4'hF;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT    = 3'd0,
        ST_REJECT    = 3'd1,
        ST_RESTART   = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_REPORT    = 3'd4
    } status_t;

    typedef enum logic {
        REG_WINDOW_LIMIT   = 1'b0,
        REG_MAX_SEND_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic load_in;
        logic check;
        logic push_dec;
        logic gap_write;
        logic bad_write;
        logic out_push;
        logic out_notready;
        logic out_empty;
        logic pop_start;
        logic pop_wr;
        logic pop_fin;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic restart;
        logic reject;
        logic pop_ready;
        logic queue_empty;
        logic queue_full;
        logic gap_zero;
        logic last_entry;
        logic out_free;
    } ctl_stat_t;

endpackage

`default_nettype wire

// ----- design/nack_loss_list_tracker.sv -----
// Top level of the NACK loss list tracker: stream ports, configuration port,
// controller and datapath. Depends on nllt_pkg, nllt_ctrl and nllt_dp.
//
// One request at a time: a push (tuser cmd 0) reports an arriving packet and
// yields one result; a pop (cmd 1) yields one report per queued lost number
// (or a single result when not ready or when the list is empty), tlast on the
// final one. An accepted push queues each skipped number in turn, then a bad
// packet's own number, then writes its result; a rejected or station-restart
// push writes its result straight after the decision. A pop with queued
// entries does a read-modify-write of each entry's send count in the loss
// queue memory, retiring leading entries during that same pass. Output stalls
// hold the sequence. The loss queue is not cleared after reset and needs no
// clearing pass. Configuration writes are always accepted and must only be
// issued while the block is idle.
`default_nettype none

module nack_loss_list_tracker
    import nllt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int SEQ_BITS    = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] seq, [39:32] station_id, [55:40] min_count
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] cmd, [1] is_good
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] nack_seq, [63:32] high_seq, [79:64] pkt_total, [87:80] station_out
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [2:0] status, [3] nack_valid, [4] overflow
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [COUNT_W-1:0]    cfg_data
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    status_t                out_status;
    logic [SEQ_FIELD_W-1:0] out_nack_seq;
    logic                   out_nack_valid;
    logic [SEQ_FIELD_W-1:0] out_high_seq;
    logic [COUNT_W-1:0]     out_pkt_total;
    logic [STATION_W-1:0]   out_station;
    logic                   out_overflow;

    assign cfg_ready = 1'b1;

    nllt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nllt_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SEQ_BITS    (SEQ_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_cmd         (s_axis_tuser[0]),
        .in_seq         (s_axis_tdata[31:0]),
        .in_good        (s_axis_tuser[1]),
        .in_station     (s_axis_tdata[39:32]),
        .in_min_count   (s_axis_tdata[55:40]),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_status     (out_status),
        .out_nack_seq   (out_nack_seq),
        .out_nack_valid (out_nack_valid),
        .out_last       (m_axis_tlast),
        .out_high_seq   (out_high_seq),
        .out_pkt_total  (out_pkt_total),
        .out_station    (out_station),
        .out_overflow   (out_overflow)
    );

    assign m_axis_tdata = {out_station, out_pkt_total, out_high_seq, out_nack_seq};
    assign m_axis_tuser = {out_overflow, out_nack_valid, out_status};

    a_gap_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gap_write |-> !stat.queue_full)
        else $error("gap write into a full loss queue");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_push || cmd.out_notready || cmd.out_empty || cmd.pop_wr) |-> stat.out_free)
        else $error("result register overwritten while held");

    a_last_report: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_wr && stat.last_entry) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("final pop report not marked last");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in progress");

endmodule

`default_nettype wire

// ----- design/nllt_ctrl.sv -----
// Sequencing state machine for the NACK loss list tracker.
// Drives ctl_cmd_t into nllt_dp from its ctl_stat_t; uses nllt_pkg.
`default_nettype none

module nllt_ctrl
    import nllt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_CHECK     = 12'b0000_0000_0010,
        S_PUSH_DEC  = 12'b0000_0000_0100,
        S_GAP       = 12'b0000_0000_1000,
        S_BAD       = 12'b0000_0001_0000,
        S_PUSH_OUT  = 12'b0000_0010_0000,
        S_POP_DEC   = 12'b0000_0100_0000,
        S_NR_OUT    = 12'b0000_1000_0000,
        S_EMPTY_OUT = 12'b0001_0000_0000,
        S_POP_RD    = 12'b0010_0000_0000,
        S_POP_WR    = 12'b0100_0000_0000,
        S_POP_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.is_pop ? S_POP_DEC : S_PUSH_DEC;
            end
            S_PUSH_DEC:
            begin
                cmd.push_dec = 1'b1;
                state_next   = (stat.restart || stat.reject) ? S_PUSH_OUT : S_GAP;
            end
            S_GAP:
            begin
                if (stat.gap_zero)
                begin
                    state_next = S_BAD;
                end
                else
                begin
                    cmd.gap_write = 1'b1;
                end
            end
            S_BAD:
            begin
                cmd.bad_write = 1'b1;
                state_next    = S_PUSH_OUT;
            end
            S_PUSH_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_POP_DEC:
            begin
                priority if (!stat.pop_ready)
                begin
                    state_next = S_NR_OUT;
                end
                else if (stat.queue_empty)
                begin
                    state_next = S_EMPTY_OUT;
                end
                else
                begin
                    cmd.pop_start = 1'b1;
                    state_next    = S_POP_RD;
                end
            end
            S_NR_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_notready = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_EMPTY_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_empty = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_POP_RD:
            begin
                if (stat.out_free)
                begin
                    state_next = S_POP_WR;
                end
            end
            S_POP_WR:
            begin
                cmd.pop_wr = 1'b1;
                state_next = stat.last_entry ? S_POP_FIN : S_POP_RD;
            end
            S_POP_FIN:
            begin
                cmd.pop_fin = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/nllt_dp.sv -----
// Datapath of the NACK loss list tracker: tracking registers, loss queue memory,
// window arithmetic and the result register. Driven by nllt_ctrl; uses nllt_pkg.
`default_nettype none

module nllt_dp
    import nllt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int SEQ_BITS    = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_cmd_t               cmd,
    output ctl_stat_t              stat,
    input  logic                   in_cmd,
    input  logic [SEQ_FIELD_W-1:0] in_seq,
    input  logic                   in_good,
    input  logic [STATION_W-1:0]   in_station,
    input  logic [COUNT_W-1:0]     in_min_count,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output status_t                out_status,
    output logic [SEQ_FIELD_W-1:0] out_nack_seq,
    output logic                   out_nack_valid,
    output logic                   out_last,
    output logic [SEQ_FIELD_W-1:0] out_high_seq,
    output logic [COUNT_W-1:0]     out_pkt_total,
    output logic [STATION_W-1:0]   out_station,
    output logic                   out_overflow
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = PTR_W + 1;
    localparam int CMP_W   = (SEQ_BITS > COUNT_W) ? SEQ_BITS : COUNT_W;
    localparam int ENTRY_W = SEQ_BITS + SEND_W;

    localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0] DEPTH_F   = FILL_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

    // configuration
    logic [COUNT_W-1:0] window_reg;
    logic [SEND_W-1:0]  max_send_reg;

    // tracking state
    logic [STATION_W-1:0] station_reg;
    logic                 station_valid_reg;
    logic [SEQ_BITS-1:0]  last_seq_reg;
    logic [COUNT_W-1:0]   pkt_count_reg;
    logic [PTR_W-1:0]     head_reg;
    logic [FILL_W-1:0]    fill_reg;

    // request hold
    logic                 in_cmd_reg;
    logic [SEQ_BITS-1:0]  in_seq_reg;
    logic                 in_good_reg;
    logic [STATION_W-1:0] in_station_reg;
    logic [COUNT_W-1:0]   in_min_count_reg;

    // check stage
    logic                restart_reg;
    logic                reject_reg;
    logic [SEQ_BITS-1:0] diff_reg;
    logic [COUNT_W-1:0]  room_reg;
    logic                pop_ready_reg;
    logic [PTR_W-1:0]    tail_full_reg;

    // push work
    status_t             res_status_reg;
    logic                ovf_reg;
    logic [FILL_W-1:0]   gap_cnt_reg;
    logic [PTR_W-1:0]    tail_reg;
    logic [SEQ_BITS-1:0] fill_val_reg;

    // pop work
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] remain_reg;
    logic [FILL_W-1:0] retire_cnt_reg;
    logic              retiring_reg;

    // result register
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [SEQ_BITS-1:0]  out_nack_reg;
    logic                 out_nvalid_reg;
    logic                 out_last_reg;
    logic [SEQ_BITS-1:0]  out_good_reg;
    logic [COUNT_W-1:0]   out_num_reg;
    logic [STATION_W-1:0] out_station_reg;
    logic                 out_ovf_reg;

    // loss queue memory
    logic [ENTRY_W-1:0] loss_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // combinational terms
    logic [SEQ_BITS:0]   seq_sub;
    logic [COUNT_W-1:0]  room_next;
    logic [SUM_W-1:0]    tail_sum;
    logic [PTR_W-1:0]    tail_full;
    logic                in_window;
    logic [COUNT_W-1:0]  diff16;
    logic [COUNT_W-1:0]  gap16;
    logic [FILL_W-1:0]   space;
    logic [COUNT_W-1:0]  space16;
    logic [FILL_W-1:0]   gap_cnt_next;
    logic                gap_ovf;
    logic [SEND_W-1:0]   cnt_old;
    logic [SEND_W-1:0]   cnt_new;
    logic                retire_hit;
    logic [SUM_W-1:0]    head_sum;
    logic [PTR_W-1:0]    head_next;
    logic                queue_full;
    logic                out_free;
    logic                bad_enq;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign seq_sub   = {1'b0, in_seq_reg} - {1'b0, last_seq_reg};
    assign room_next = (pkt_count_reg < window_reg) ? (window_reg - pkt_count_reg) : '0;
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_full = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);

    assign in_window    = CMP_W'(diff_reg) <= CMP_W'(room_reg);
    assign diff16       = COUNT_W'(CMP_W'(diff_reg));
    assign gap16        = diff16 - 1'b1;
    assign space        = DEPTH_F - fill_reg;
    assign space16      = COUNT_W'(space);
    assign gap_cnt_next = (gap16 < space16) ? FILL_W'(gap16) : space;
    assign gap_ovf      = gap16 > space16;

    assign cnt_old    = rd_data_reg[SEQ_BITS +: SEND_W];
    assign cnt_new    = (cnt_old == SEND_SAT) ? cnt_old : cnt_old + 1'b1;
    assign retire_hit = retiring_reg && (cnt_new >= max_send_reg);

    assign head_sum  = SUM_W'(head_reg) + SUM_W'(retire_cnt_reg);
    assign head_next = (head_sum >= DEPTH_S) ? PTR_W'(head_sum - DEPTH_S) : PTR_W'(head_sum);

    assign queue_full = (fill_reg == DEPTH_F);
    assign out_free   = !out_valid_reg || out_ready;
    assign bad_enq    = cmd.bad_write && !in_good_reg && !queue_full;

    assign stat.is_pop      = (in_cmd_reg == CMD_POP);
    assign stat.restart     = restart_reg;
    assign stat.reject      = reject_reg;
    assign stat.pop_ready   = pop_ready_reg;
    assign stat.queue_empty = (fill_reg == '0);
    assign stat.queue_full  = queue_full;
    assign stat.gap_zero    = (gap_cnt_reg == '0);
    assign stat.last_entry  = (remain_reg == FILL_W'(1));
    assign stat.out_free    = out_free;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = tail_reg;
        mem_wdata = {{SEND_W{1'b0}}, fill_val_reg};
        priority if (cmd.gap_write)
        begin
            mem_we = 1'b1;
        end
        else if (bad_enq)
        begin
            mem_we    = 1'b1;
            mem_wdata = {{SEND_W{1'b0}}, in_seq_reg};
        end
        else if (cmd.pop_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_ptr_reg;
            mem_wdata = {cnt_new, rd_data_reg[SEQ_BITS-1:0]};
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            loss_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= loss_mem[rd_ptr_reg];
    end

    // control and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg        <= WINDOW_LIMIT_RST;
            max_send_reg      <= MAX_SEND_RST;
            station_reg       <= '0;
            station_valid_reg <= 1'b0;
            last_seq_reg      <= '0;
            pkt_count_reg     <= '0;
            head_reg          <= '0;
            fill_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WINDOW_LIMIT)
                begin
                    window_reg <= cfg_data;
                end
                else
                begin
                    max_send_reg <= cfg_data[SEND_W-1:0];
                end
            end

            if (cmd.push_dec)
            begin
                priority if (restart_reg)
                begin
                    station_reg       <= in_station_reg;
                    station_valid_reg <= 1'b1;
                    fill_reg          <= '0;
                    pkt_count_reg     <= '0;
                    last_seq_reg      <= in_seq_reg;
                end
                else if (!reject_reg)
                begin
                    last_seq_reg <= in_seq_reg;
                    if (in_window)
                    begin
                        pkt_count_reg <= pkt_count_reg + diff16;
                    end
                    else
                    begin
                        fill_reg      <= '0;
                        pkt_count_reg <= COUNT_W'(1);
                    end
                end
                else
                begin
                    last_seq_reg <= last_seq_reg;
                end
            end

            if (cmd.gap_write || bad_enq)
            begin
                fill_reg <= fill_reg + 1'b1;
            end

            if (cmd.out_empty)
            begin
                pkt_count_reg <= '0;
            end

            if (cmd.pop_fin)
            begin
                head_reg      <= head_next;
                fill_reg      <= fill_reg - retire_cnt_reg;
                pkt_count_reg <= '0;
            end

            if (cmd.out_push || cmd.out_notready || cmd.out_empty || cmd.pop_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request hold, work registers and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_cmd_reg       <= in_cmd;
            in_seq_reg       <= in_seq[SEQ_BITS-1:0];
            in_good_reg      <= in_good;
            in_station_reg   <= in_station;
            in_min_count_reg <= in_min_count;
        end

        if (cmd.check)
        begin
            restart_reg   <= !station_valid_reg || (in_station_reg != station_reg);
            reject_reg    <= seq_sub[SEQ_BITS] || (seq_sub[SEQ_BITS-1:0] == '0);
            diff_reg      <= seq_sub[SEQ_BITS-1:0];
            room_reg      <= room_next;
            pop_ready_reg <= pkt_count_reg >= in_min_count_reg;
            tail_full_reg <= tail_full;
        end

        if (cmd.push_dec)
        begin
            fill_val_reg <= last_seq_reg + 1'b1;
            priority if (restart_reg)
            begin
                res_status_reg <= ST_RESTART;
                ovf_reg        <= 1'b0;
                gap_cnt_reg    <= '0;
            end
            else if (reject_reg)
            begin
                res_status_reg <= ST_REJECT;
                ovf_reg        <= 1'b0;
                gap_cnt_reg    <= '0;
            end
            else
            begin
                res_status_reg <= ST_ACCEPT;
                if (in_window)
                begin
                    gap_cnt_reg <= gap_cnt_next;
                    ovf_reg     <= gap_ovf;
                    tail_reg    <= tail_full_reg;
                end
                else
                begin
                    gap_cnt_reg <= '0;
                    ovf_reg     <= 1'b0;
                    tail_reg    <= head_reg;
                end
            end
        end

        if (cmd.gap_write)
        begin
            tail_reg     <= ptr_inc(tail_reg);
            fill_val_reg <= fill_val_reg + 1'b1;
            gap_cnt_reg  <= gap_cnt_reg - 1'b1;
        end

        if (cmd.bad_write && !in_good_reg && queue_full)
        begin
            ovf_reg <= 1'b1;
        end

        if (cmd.pop_start)
        begin
            rd_ptr_reg     <= head_reg;
            remain_reg     <= fill_reg;
            retire_cnt_reg <= '0;
            retiring_reg   <= 1'b1;
        end

        if (cmd.pop_wr)
        begin
            rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            remain_reg <= remain_reg - 1'b1;
            if (retire_hit)
            begin
                retire_cnt_reg <= retire_cnt_reg + 1'b1;
            end
            else
            begin
                retiring_reg <= 1'b0;
            end
        end

        priority if (cmd.out_push || cmd.out_notready)
        begin
            out_status_reg  <= cmd.out_push ? res_status_reg : ST_NOT_READY;
            out_nack_reg    <= '0;
            out_nvalid_reg  <= 1'b0;
            out_last_reg    <= 1'b1;
            out_good_reg    <= '0;
            out_num_reg     <= '0;
            out_station_reg <= '0;
            out_ovf_reg     <= cmd.out_push && ovf_reg;
        end
        else if (cmd.out_empty || cmd.pop_wr)
        begin
            out_status_reg  <= ST_REPORT;
            out_nack_reg    <= cmd.pop_wr ? rd_data_reg[SEQ_BITS-1:0] : '0;
            out_nvalid_reg  <= cmd.pop_wr;
            out_last_reg    <= cmd.out_empty || (remain_reg == FILL_W'(1));
            out_good_reg    <= last_seq_reg;
            out_num_reg     <= pkt_count_reg;
            out_station_reg <= station_reg;
            out_ovf_reg     <= 1'b0;
        end
        else
        begin
            out_ovf_reg <= out_ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_nack_seq   = SEQ_FIELD_W'(out_nack_reg);
    assign out_nack_valid = out_nvalid_reg;
    assign out_last       = out_last_reg;
    assign out_high_seq   = SEQ_FIELD_W'(out_good_reg);
    assign out_pkt_total  = out_num_reg;
    assign out_station    = out_station_reg;
    assign out_overflow   = out_ovf_reg;

endmodule

`default_nettype wire
